### design/bdq_pkg.sv
// shared types and constants for the bounded deque with indexed read
// no dependencies; imported by the controller, datapath and top level

package bdq_pkg;

    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;
    localparam int M_PAD_W    = M_TDATA_W - VALUE_W - COUNT_W - 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ_FRONT = 3'd4,
        KIND_READ_BACK  = 3'd5,
        KIND_READ_AT    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    typedef struct packed {
        logic accept;
        logic capture;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic read_kind;
    } dp_status_t;

endpackage

### design/bounded_deque_with_indexed_read.sv
// top level of the bounded deque with indexed read
// depends on bdq_pkg, bdq_ctrl, bdq_datapath and bdq_ram
//
// channel   dir  group                   contents
// s_axis    in   s_tvalid/tready/tdata   tuser: kind; tdata: entry_value, position
// m_axis    out  m_tvalid/tready/tdata   tuser: read_valid; tdata: read_value, refused,
//                                        entry_count, is_full, is_empty
//
// pushes, pops and the unused kind load the output register directly; reads pass first
// through the registered read port of the ring store ram
// one item is in flight at a time; the next is taken at the edge the last result leaves
// reset clears pointer, count and output valid; ram contents are not cleared
// a stalled result holds in the output register and blocks only new items

module bounded_deque_with_indexed_read #(
    parameter int DEPTH      = 256,
    parameter int ENTRY_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bdq_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_value[31:0], position[39:32]
    input  logic [bdq_pkg::KIND_W-1:0]     s_tuser,   // kind[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_tdata,   // read_value[31:0], refused[32],
                                                      // entry_count[41:33], is_full[42],
                                                      // is_empty[43], zero[47:44]
    output logic [bdq_pkg::M_TUSER_W-1:0]  m_tuser    // read_valid[0]
);

    import bdq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdq_datapath #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### design/bdq_ram.sv
// generic single-port ram with registered read
// no dependencies; holds the ring store of the deque

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bdq_ctrl.sv
// controller state machine of the deque: handshake and read sequencing
// depends on bdq_pkg; drives commands into bdq_datapath

module bdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    input  bdq_pkg::dp_status_t status,
    output bdq_pkg::dp_cmd_t    cmd
);

    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = !status.out_valid || m_tready;
                cmd.accept = s_tvalid && s_tready;
                if (cmd.accept && status.read_kind)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_capture_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> $past(cmd.accept))
        else $error("ram data captured without a read item accepted");

    a_read_state_on_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> ((state_reg == ST_READ) == $past(status.read_kind)))
        else $error("read wait state does not match the accepted kind");

endmodule

### design/bdq_datapath.sv
// datapath of the deque: front pointer, count, ring addressing, output register
// depends on bdq_pkg and bdq_ram; commanded by bdq_ctrl

module bdq_datapath #(
    parameter int DEPTH      = 256,
    parameter int ENTRY_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bdq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [bdq_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [bdq_pkg::M_TUSER_W-1:0]  m_tuser,
    input  bdq_pkg::dp_cmd_t               cmd,
    output bdq_pkg::dp_status_t            status
);

    import bdq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW:0]   DEPTH_S = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    logic [PW-1:0] front_reg;
    logic [PW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  rd_valid_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic                  refused_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic                  full_out_reg;
    logic                  empty_out_reg;
    logic                  rd_ok_reg;

    kind_t            kind;
    logic [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0] position;
    logic             full;
    logic             empty;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    cnt_x;
    logic [CW-1:0]    cnt_m1;
    logic [PW-1:0]    front_dec;
    logic [PW-1:0]    offset;
    logic [PW:0]      slot_sum;
    logic [PW-1:0]    slot;
    logic [PW-1:0]    addr;
    logic             we;
    logic             is_rd;
    logic             rd_ok;
    logic             refuse;
    logic [ENTRY_BITS-1:0] rdata;

    assign kind        = kind_t'(s_tuser);
    assign entry_value = s_tdata[VALUE_W-1:0];
    assign position    = s_tdata[VALUE_W +: POS_W];
    assign full        = (count_reg == DEPTH_C);
    assign empty       = (count_reg == '0);
    assign pos_x       = XW'(position);
    assign cnt_x       = XW'(count_reg);
    assign cnt_m1      = count_reg - CW'(1);
    assign front_dec   = (front_reg == '0) ? LAST_SLOT : (front_reg - PW'(1));

    // offset from the front for the slot an item addresses
    always_comb
    begin
        unique case (kind)
            KIND_PUSH_BACK: offset = count_reg[PW-1:0];
            KIND_POP_FRONT: offset = PW'(1);
            KIND_READ_BACK: offset = cnt_m1[PW-1:0];
            KIND_READ_AT:   offset = pos_x[PW-1:0];
            default:        offset = '0;
        endcase
    end

    // front plus offset, wrapped once into the ring
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= DEPTH_S) ? PW'(slot_sum - DEPTH_S) : slot_sum[PW-1:0];

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        addr       = slot;
        we         = 1'b0;
        is_rd      = 1'b0;
        rd_ok      = 1'b0;
        refuse     = 1'b0;
        unique case (kind)
            KIND_PUSH_FRONT:
            begin
                addr = front_dec;
                if (full)
                begin
                    refuse = 1'b1;
                end
                else
                begin
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                    we         = 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    refuse = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    we         = 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                begin
                    refuse = 1'b1;
                end
                else
                begin
                    front_next = slot;
                    count_next = cnt_m1;
                end
            end
            KIND_POP_BACK:
            begin
                if (empty)
                begin
                    refuse = 1'b1;
                end
                else
                begin
                    count_next = cnt_m1;
                end
            end
            KIND_READ_FRONT:
            begin
                is_rd = 1'b1;
                rd_ok = !empty;
            end
            KIND_READ_BACK:
            begin
                is_rd  = 1'b1;
                rd_ok  = !empty;
            end
            KIND_READ_AT:
            begin
                is_rd  = 1'b1;
                rd_ok  = (pos_x < cnt_x);
            end
            default:
            begin
                // unused kind code: no operation
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.accept && (we || is_rd)),
        .we    (we),
        .addr  (addr),
        .wdata (ENTRY_BITS'(entry_value)),
        .rdata (rdata)
    );

    always_comb
    begin
        if ((cmd.accept && !is_rd) || cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_valid_reg  <= 1'b0;
            value_reg     <= '0;
            refused_reg   <= refuse;
            count_out_reg <= COUNT_W'(count_next);
            full_out_reg  <= (count_next == DEPTH_C);
            empty_out_reg <= (count_next == '0);
            rd_ok_reg     <= rd_ok;
        end
        else if (cmd.capture)
        begin
            rd_valid_reg <= rd_ok_reg;
            value_reg    <= rd_ok_reg ? VALUE_W'(rdata) : '0;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.read_kind = is_rd;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rd_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, empty_out_reg, full_out_reg, count_out_reg,
                       refused_reg, value_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("held count beyond capacity");

    a_refused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && refuse) |=>
            (count_reg == $past(count_reg)) && (front_reg == $past(front_reg)))
        else $error("refused item changed the pointers");

    a_valid_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rd_valid_reg) |-> !empty_out_reg)
        else $error("valid read reported on an empty list");

endmodule
